/* rtl/core/assert_macros.svh */
// Assertion macros used by the RTL file that checks its own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, sampled on clk, off while rst is high.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* rtl/core/ndss_pkg.sv */
// Shared types and constants of the descriptor status statistics block.
`default_nettype none

package ndss_pkg;

  localparam int MAX_FRAME_LEN = 1518;
  localparam int NUM_COUNTERS  = 17;
  localparam int QDEPTH        = 4;
  localparam int QPTR_W        = $clog2(QDEPTH);
  localparam int QCNT_W        = QPTR_W + 1;

  // Statistics counter indexes
  localparam int C_RX_PACKETS   = 0;
  localparam int C_RX_BYTES     = 1;
  localparam int C_RX_ERRORS    = 2;
  localparam int C_RX_LENGTH    = 3;
  localparam int C_RX_FRAME     = 4;
  localparam int C_RX_CRC       = 5;
  localparam int C_RX_FIFO      = 6;
  localparam int C_RX_DROPPED   = 7;
  localparam int C_TX_PACKETS   = 8;
  localparam int C_TX_BYTES     = 9;
  localparam int C_TX_ERRORS    = 10;
  localparam int C_TX_ABORTED   = 11;
  localparam int C_TX_CARRIER   = 12;
  localparam int C_TX_WINDOW    = 13;
  localparam int C_TX_FIFO      = 14;
  localparam int C_TX_HEARTBEAT = 15;
  localparam int C_COLLISIONS   = 16;

  typedef enum logic [1:0] {
    CMD_RX     = 2'd0,
    CMD_TX     = 2'd1,
    CMD_MISSED = 2'd2,
    CMD_READ   = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    OUT_OWNED   = 3'd0,
    OUT_GOOD    = 3'd1,
    OUT_ERROR   = 3'd2,
    OUT_IGNORED = 3'd3,
    OUT_ACCEPT  = 3'd4
  } outcome_t;

  // One classified item as it waits between front and back
  typedef struct packed {
    outcome_t                  outcome;
    logic [10:0]               rx_len;
    logic [NUM_COUNTERS-1:0]   inc;
    logic [10:0]               byte_amt;
    logic [3:0]                coll_amt;
    logic [16:0]               drop_amt;
    logic                      is_read;
    logic [4:0]                sel;
  } entry_t;

  typedef struct packed {
    logic              full;
    logic              empty;
    logic [QCNT_W-1:0] count;
  } qstat_t;

endpackage

`default_nettype wire

/* rtl/core/ndss_front.sv */
// Front end: classifies one input item into counter updates and a result.
`default_nettype none

module ndss_front (
  input  wire logic [1:0]      cmd,
  input  wire logic [31:0]     desc_status,
  input  wire logic [10:0]     tx_frame_len,
  input  wire logic            filter_setup,
  input  wire logic [16:0]     missed_sample,
  input  wire logic [4:0]      counter_select,
  input  wire logic            fdx_mode,
  output ndss_pkg::entry_t     entry
);
  import ndss_pkg::*;

  logic [10:0] field;
  logic [10:0] len;

  // receive length without CRC
  always_comb begin
    field = desc_status[26:16];
    len   = (field < 11'd4) ? 11'd0 : field - 11'd4;
  end

  always_comb begin
    entry          = '0;
    entry.outcome  = OUT_ACCEPT;
    entry.byte_amt = 11'd0;
    entry.sel      = counter_select;
    case (cmd_t'(cmd))
      CMD_RX: begin
        if (desc_status[31]) begin
          entry.outcome = OUT_OWNED;
        end else if ((desc_status & 32'h3800_8300) != 32'h0000_0300) begin
          entry.outcome = OUT_ERROR;
          if ((desc_status & 32'h3800_0300) != 32'h0000_0300) begin
            // frame spans buffers
            if (desc_status[15:0] == 16'h7fff) begin
              entry.outcome = OUT_IGNORED;
            end else begin
              entry.inc[C_RX_LENGTH] = 1'b1;
            end
          end else begin
            // single buffer with error summary
            entry.inc[C_RX_ERRORS] = 1'b1;
            entry.inc[C_RX_LENGTH] = |(desc_status & 32'h0000_0890);
            entry.inc[C_RX_FRAME]  = desc_status[2];
            entry.inc[C_RX_CRC]    = desc_status[1];
            entry.inc[C_RX_FIFO]   = desc_status[0];
          end
        end else begin
          entry.outcome = OUT_GOOD;
          if (len > 11'(MAX_FRAME_LEN)) begin
            entry.rx_len           = 11'(MAX_FRAME_LEN);
            entry.inc[C_RX_LENGTH] = 1'b1;
          end else begin
            entry.rx_len = len;
          end
          entry.byte_amt          = entry.rx_len;
          entry.inc[C_RX_PACKETS] = 1'b1;
          entry.inc[C_RX_BYTES]   = 1'b1;
        end
      end
      CMD_TX: begin
        if (desc_status[31]) begin
          entry.outcome = OUT_OWNED;
        end else if (filter_setup) begin
          entry.outcome = OUT_IGNORED;
        end else if (desc_status[15]) begin
          entry.outcome             = OUT_ERROR;
          entry.inc[C_TX_ERRORS]    = 1'b1;
          entry.inc[C_TX_ABORTED]   = |(desc_status & 32'h0000_4104);
          entry.inc[C_TX_CARRIER]   = |(desc_status & 32'h0000_0C00);
          entry.inc[C_TX_WINDOW]    = desc_status[9];
          entry.inc[C_TX_FIFO]      = desc_status[1];
          entry.inc[C_TX_HEARTBEAT] = desc_status[7] & ~fdx_mode;
        end else begin
          entry.outcome           = OUT_GOOD;
          entry.byte_amt          = tx_frame_len;
          entry.coll_amt          = desc_status[6:3];
          entry.inc[C_TX_BYTES]   = 1'b1;
          entry.inc[C_COLLISIONS] = 1'b1;
          entry.inc[C_TX_PACKETS] = 1'b1;
        end
      end
      CMD_MISSED: begin
        // overflow adds one full wrap of the 16-bit count
        entry.drop_amt          = missed_sample[16] ? 17'h1_0000 : missed_sample;
        entry.inc[C_RX_DROPPED] = |missed_sample;
      end
      CMD_READ: begin
        if (counter_select < 5'(NUM_COUNTERS)) begin
          entry.is_read = 1'b1;
        end else begin
          entry.outcome = OUT_IGNORED;
        end
      end
      default: begin
        entry.outcome = OUT_IGNORED;
      end
    endcase
  end

endmodule

`default_nettype wire

/* rtl/core/ndss_queue.sv */
// Short in-order queue of classified items between front and back.
`default_nettype none

module ndss_queue (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  ndss_pkg::entry_t      push_data,
  input  wire logic             pop,
  output ndss_pkg::entry_t      pop_data,
  output ndss_pkg::qstat_t      stat
);
  import ndss_pkg::*;

  entry_t            slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_data;
  end

  assign pop_data   = slots[rd_ptr];
  assign stat.full  = (count == QCNT_W'(QDEPTH));
  assign stat.empty = (count == '0);
  assign stat.count = count;

endmodule

`default_nettype wire

/* rtl/core/ndss_back.sv */
// Back end: applies counter updates in order and holds the result register.
`default_nettype none

module ndss_back (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         q_empty,
  input  ndss_pkg::entry_t  q_data,
  output logic              pop,
  input  wire logic         out_stall,
  output logic              out_valid,
  output logic [2:0]        outcome,
  output logic [10:0]       rx_length,
  output logic [31:0]       counter_value
);
  import ndss_pkg::*;

  logic [31:0] counters [NUM_COUNTERS];
  logic [31:0] amount   [NUM_COUNTERS];
  logic [4:0]  rd_sel;
  logic [31:0] rd_value;

  // take the next item when the result register is free or being drained
  assign pop = ~q_empty & (~out_valid | ~out_stall);

  // per-counter add amount
  always_comb begin
    for (int i = 0; i < NUM_COUNTERS; i++) begin
      amount[i] = 32'd1;
    end
    amount[C_RX_BYTES]   = 32'(q_data.byte_amt);
    amount[C_TX_BYTES]   = 32'(q_data.byte_amt);
    amount[C_COLLISIONS] = 32'(q_data.coll_amt);
    amount[C_RX_DROPPED] = 32'(q_data.drop_amt);
  end

  // counter read sees every earlier item's update
  always_comb begin
    rd_sel   = q_data.is_read ? q_data.sel : 5'd0;
    rd_value = q_data.is_read ? counters[rd_sel] : 32'd0;
  end

  // wrapping statistics counters
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_COUNTERS; i++) counters[i] <= 32'd0;
    end else if (pop) begin
      for (int i = 0; i < NUM_COUNTERS; i++) begin
        if (q_data.inc[i]) counters[i] <= counters[i] + amount[i];
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (~out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      outcome       <= q_data.outcome;
      rx_length     <= q_data.rx_len;
      counter_value <= rd_value;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/nic_descriptor_status_statistics.sv */
// Top level of the descriptor status statistics block.
//
//  channel  | direction | transfer when          | payload
//  ---------+-----------+------------------------+--------------------------------
//  input    | in        | in_valid & !in_stall   | cmd, desc_status, tx_frame_len,
//           |           |                        | filter_setup, missed_sample,
//           |           |                        | counter_select
//  result   | out       | out_valid & !out_stall | outcome, rx_length, counter_value
//  config   | in        | psel&penable&pwrite    | fdx_mode at byte addresses 0-3
//
// One item per cycle sustained while out_stall stays low; each input is queued,
// then popped into the result register as the back end updates the counters.
// The four-entry queue absorbs result stalls; in_stall rises only when it is full.
// Synchronous reset clears all seventeen counters, the queue and fdx_mode at once.
`default_nettype none
`include "assert_macros.svh"

module nic_descriptor_status_statistics (
  input  wire logic        clk,
  input  wire logic        rst,
  // input channel
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  cmd,
  input  wire logic [31:0] desc_status,
  input  wire logic [10:0] tx_frame_len,
  input  wire logic        filter_setup,
  input  wire logic [16:0] missed_sample,
  input  wire logic [4:0]  counter_select,
  // result channel
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       outcome,
  output logic [10:0]      rx_length,
  output logic [31:0]      counter_value,
  // configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import ndss_pkg::*;

  logic   fdx_mode;
  entry_t front_entry;
  entry_t q_data;
  qstat_t q_stat;
  logic   push;
  logic   pop;

  // configuration register
  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'd0 : 32'(fdx_mode);

  always_ff @(posedge clk) begin
    if (rst) begin
      fdx_mode <= 1'b0;
    end else if (psel && penable && pwrite && pready && !paddr[2]) begin
      fdx_mode <= pwdata[0];
    end
  end

  assign in_stall = q_stat.full;
  assign push     = in_valid & ~q_stat.full;

  ndss_front u_front (
    .cmd            (cmd),
    .desc_status    (desc_status),
    .tx_frame_len   (tx_frame_len),
    .filter_setup   (filter_setup),
    .missed_sample  (missed_sample),
    .counter_select (counter_select),
    .fdx_mode       (fdx_mode),
    .entry          (front_entry)
  );

  ndss_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (front_entry),
    .pop       (pop),
    .pop_data  (q_data),
    .stat      (q_stat)
  );

  ndss_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_empty       (q_stat.empty),
    .q_data        (q_data),
    .pop           (pop),
    .out_stall     (out_stall),
    .out_valid     (out_valid),
    .outcome       (outcome),
    .rx_length     (rx_length),
    .counter_value (counter_value)
  );

  // checks on queue bookkeeping and result consistency
  `ASSERT_SAME(a_q_bound, 1'b1, q_stat.count <= QCNT_W'(QDEPTH))
  `ASSERT_NEXT(a_q_fill, push && !pop && !q_stat.full, !q_stat.empty)
  `ASSERT_SAME(a_len_good, out_valid && outcome != OUT_GOOD, rx_length == 11'd0)
  `ASSERT_SAME(a_len_max, out_valid, rx_length <= 11'(MAX_FRAME_LEN))
  `ASSERT_SAME(a_val_read, out_valid && counter_value != 32'd0, outcome == OUT_ACCEPT)

endmodule

`default_nettype wire
